[design/sspp_pkg.sv]
`timescale 1ns / 1ps

package sspp_pkg;

   localparam logic [8:0]  STEPS_PER_TURN  = 9'd400;
   localparam logic [8:0]  LAST_STEP       = 9'd399;
   localparam logic [13:0] HALF_TURN       = 14'd1800;
   localparam logic [13:0] FULL_TURN       = 14'd3600;
   localparam logic [3:0]  PHASE_COUNT     = 4'd8;
   localparam logic [3:0]  CCW_START_PHASE = 4'd7;
   localparam logic [3:0]  FIRST_PHASE     = 4'd1;
   localparam logic [10:0] ROUND_BIAS      = 11'd4;
   // ceil(2^16 / 9), exact for dividends up to 1804
   localparam logic [23:0] RECIP_NINE      = 24'd7282;

   localparam logic REQ_TARGET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic [8:0] position;
      logic [7:0] remaining;
      logic       ccw;
      logic [3:0] phase;
      logic [3:0] coil;
   } state_type;

   function automatic logic [3:0] coil_of(input logic [3:0] phase);
      logic [3:0] pattern;
      case (phase)
         4'd1:    pattern = 4'h8;
         4'd2:    pattern = 4'hC;
         4'd3:    pattern = 4'h4;
         4'd4:    pattern = 4'h6;
         4'd5:    pattern = 4'h2;
         4'd6:    pattern = 4'h3;
         4'd7:    pattern = 4'h1;
         4'd8:    pattern = 4'h9;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

   // position in tenths of a degree: times 9 as shift and add
   function automatic logic [11:0] tenths_of(input logic [8:0] position);
      return ({3'd0, position} << 3) + {3'd0, position};
   endfunction

endpackage

[design/sspp_step.sv]
`timescale 1ns / 1ps

module sspp_step (
   input  logic                 req_kind,
   input  logic [11:0]          target,
   input  sspp_pkg::state_type  state_cur,
   output sspp_pkg::state_type  state_next
);

   logic [11:0] cur_tenths;
   logic [13:0] diff_raw;
   logic [13:0] diff;
   logic [13:0] diff_abs;
   logic [10:0] rounded;
   logic [23:0] product;
   logic [7:0]  steps;
   logic [3:0]  phase_up;
   logic [3:0]  phase_dn;
   logic [3:0]  phase_new;

   always_comb begin
      cur_tenths = sspp_pkg::tenths_of(state_cur.position);
      diff_raw   = {2'd0, target} - {2'd0, cur_tenths};
      // fold into -1800..+1800, the ends themselves stay
      if ($signed(diff_raw) > $signed(sspp_pkg::HALF_TURN)) begin
         diff = diff_raw - sspp_pkg::FULL_TURN;
      end else if ($signed(diff_raw) < -$signed(sspp_pkg::HALF_TURN)) begin
         diff = diff_raw + sspp_pkg::FULL_TURN;
      end else begin
         diff = diff_raw;
      end
      diff_abs = diff[13] ? (~diff + 14'd1) : diff;
      rounded  = diff_abs[10:0] + sspp_pkg::ROUND_BIAS;
      product  = {13'd0, rounded} * sspp_pkg::RECIP_NINE;
      steps    = product[23:16];
   end

   always_comb begin
      phase_up = (state_cur.phase >= sspp_pkg::PHASE_COUNT) ? sspp_pkg::FIRST_PHASE
                                                            : state_cur.phase + 4'd1;
      if (state_cur.phase == 4'd0) begin
         phase_dn = sspp_pkg::CCW_START_PHASE;
      end else if (state_cur.phase == sspp_pkg::FIRST_PHASE) begin
         phase_dn = sspp_pkg::PHASE_COUNT;
      end else begin
         phase_dn = state_cur.phase - 4'd1;
      end
      phase_new = state_cur.ccw ? phase_dn : phase_up;
      if (phase_new > sspp_pkg::PHASE_COUNT) begin
         phase_new = sspp_pkg::FIRST_PHASE;
      end
   end

   always_comb begin
      state_next = state_cur;
      if (req_kind == sspp_pkg::REQ_TARGET) begin
         state_next.remaining = steps;
         state_next.ccw       = diff[13] && (steps != 8'd0);
      end else if (state_cur.remaining != 8'd0) begin
         state_next.phase     = phase_new;
         state_next.coil      = sspp_pkg::coil_of(phase_new);
         state_next.remaining = state_cur.remaining - 8'd1;
         if (state_cur.ccw) begin
            state_next.position = (state_cur.position == 9'd0) ? sspp_pkg::LAST_STEP
                                                                : state_cur.position - 9'd1;
         end else begin
            state_next.position = (state_cur.position + 9'd1 >= sspp_pkg::STEPS_PER_TURN)
                                  ? 9'd0 : state_cur.position + 9'd1;
         end
      end
   end

endmodule

[design/stepper_shortest_path_positioner.sv]
`timescale 1ns / 1ps

// Positions a 400-step-per-turn stepper (0.9 degree per step) in half steps.
// A target transaction (tuser 0) sets a new goal angle in tenths of a degree;
// the move takes the shorter way round, at most 200 steps, and replaces any
// move in progress. A tick transaction (tuser 1) takes one step if steps
// remain. Every transaction returns one response with the state after it.
// A transaction passes one input register and then one response register from
// acceptance to response, with the target fold, rounding divide by nine and step
// update between them; one transaction is taken every cycle while rsp_tready allows.

module stepper_shortest_path_positioner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] target_tenths, rest zero
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [3:0] coil_pattern, [4] turn_ccw,
                                    // [12:5] steps_left, [21:13] position_steps,
                                    // [33:22] angle_tenths, [34] busy_res
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic                in_kind_ff;
   logic [11:0]         in_target_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [39:0]         out_data_ff;
   logic                out_load;
   logic                in_load;
   sspp_pkg::state_type state_ff;
   sspp_pkg::state_type state_in;

   sspp_step u_step (
      .req_kind   (in_kind_ff),
      .target     (in_target_ff),
      .state_cur  (state_ff),
      .state_next (state_in)
   );

   always_comb begin
      out_load     = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || out_load;
      in_load      = req_tvalid && req_tready;
      in_valid_in  = in_load || (in_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_kind_ff   <= req_tuser;
         in_target_ff <= req_tdata[11:0];
      end
      if (out_load) begin
         out_data_ff <= {5'd0,
                         state_in.remaining != 8'd0,
                         sspp_pkg::tenths_of(state_in.position),
                         state_in.position,
                         state_in.remaining,
                         state_in.ccw,
                         state_in.coil};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[test/positioner_checker.sv]
`timescale 1ns / 1ps

module positioner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] target_tenths, rest zero
   input  logic        req_tuser,   // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [3:0] coil_pattern, [4] turn_ccw,
                                    // [12:5] steps_left, [21:13] position_steps,
                                    // [33:22] angle_tenths, [34] busy_res
   output int          fail_count,
   output int          pending_count
);

   localparam int STEP_TENTHS      = 9;
   localparam int HALF_TURN_TENTHS = 1800;
   localparam int FULL_TURN_TENTHS = 3600;
   localparam int ROUND_UP         = 4;
   localparam int STEP_CAP         = 255;
   localparam int MAX_REPORTS      = 100;
   localparam logic [3:0] NO_PHASE = 4'd0;
   // coil drive for phases 0..8, phase 0 in the lowest nibble
   localparam logic [35:0] COIL_SEQUENCE = 36'h913264C80;

   typedef struct packed {
      logic        busy;
      logic [11:0] angle;
      logic [8:0]  position;
      logic [7:0]  steps;
      logic        ccw;
      logic [3:0]  coil;
   } motor_report_type;

   sspp_pkg::state_type motor;
   motor_report_type    expected_reports[$];
   int                  faults = 0;

   task automatic step_motor();
      if (motor.remaining != 8'd0) begin
         if (!motor.ccw)
            motor.phase = (motor.phase >= sspp_pkg::PHASE_COUNT) ? sspp_pkg::FIRST_PHASE
                                                                 : motor.phase + 4'd1;
         else if (motor.phase == NO_PHASE)
            motor.phase = sspp_pkg::CCW_START_PHASE;
         else if (motor.phase == sspp_pkg::FIRST_PHASE)
            motor.phase = sspp_pkg::PHASE_COUNT;
         else
            motor.phase = motor.phase - 4'd1;
         motor.coil = COIL_SEQUENCE[motor.phase * 4 +: 4];
         if (motor.ccw)
            motor.position = (motor.position == 9'd0) ? sspp_pkg::LAST_STEP
                                                      : motor.position - 9'd1;
         else
            motor.position = (motor.position == sspp_pkg::LAST_STEP) ? 9'd0
                                                                     : motor.position + 9'd1;
         motor.remaining = motor.remaining - 8'd1;
      end
   endtask

   task automatic aim_motor(input logic [11:0] target);
      int goal;
      int here;
      int tenths_diff;
      int step_count;
      goal = target;
      here = motor.position;
      tenths_diff = goal - here * STEP_TENTHS;
      // take the shorter way round; an exact half turn keeps its sign
      if (tenths_diff > HALF_TURN_TENTHS)
         tenths_diff = tenths_diff - FULL_TURN_TENTHS;
      else if (tenths_diff < -HALF_TURN_TENTHS)
         tenths_diff = tenths_diff + FULL_TURN_TENTHS;
      step_count = ((tenths_diff < 0) ? -tenths_diff : tenths_diff) + ROUND_UP;
      step_count = step_count / STEP_TENTHS;
      if (step_count > STEP_CAP)
         step_count = STEP_CAP;
      motor.remaining = step_count[7:0];
      motor.ccw = (tenths_diff < 0) && (step_count != 0);
   endtask

   function automatic motor_report_type snapshot();
      motor_report_type rep;
      rep.coil     = motor.coil;
      rep.ccw      = motor.ccw;
      rep.steps    = motor.remaining;
      rep.position = motor.position;
      rep.angle    = {3'd0, motor.position} * 12'd9;
      rep.busy     = (motor.remaining != 8'd0);
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
      if (got !== want) begin
         faults++;
         if (faults <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      motor_report_type seen;
      motor_report_type want;
      if (reset) begin
         motor = '0;
         expected_reports.delete();
         faults = 0;
      end else begin
         // responses trail their transaction through registers, so pop first
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[34:0];
            if (expected_reports.size() == 0) begin
               faults++;
               if (faults <= MAX_REPORTS)
                  $error("response with no transaction outstanding");
            end else begin
               want = expected_reports.pop_front();
               check_field("coil_pattern", want.coil, seen.coil);
               check_field("turn_ccw", want.ccw, seen.ccw);
               check_field("steps_left", want.steps, seen.steps);
               check_field("position_steps", want.position, seen.position);
               check_field("angle_tenths", want.angle, seen.angle);
               check_field("busy_res", want.busy, seen.busy);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == sspp_pkg::REQ_TICK)
               step_motor();
            else
               aim_motor(req_tdata[11:0]);
            expected_reports.push_back(snapshot());
         end
      end
      fail_count    <= faults;
      pending_count <= expected_reports.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int ITEM_GOAL     = 1150;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 36;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_RUN      = 205;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'd0;
   logic        req_tuser  = sspp_pkg::REQ_TARGET;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        steady     = 1'b0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stepper_shortest_path_positioner uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   positioner_checker motion_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic send(input logic kind, input logic [11:0] target);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, target};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // hold off until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin : stimulus
      logic [11:0] aim;
      int          ticks;
      logic        paused_late;
      paused_late = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(sspp_pkg::REQ_TICK, 12'd0);        // tick at rest, no phase yet
      send(sspp_pkg::REQ_TARGET, 12'd0);      // zero-step target
      send(sspp_pkg::REQ_TARGET, 12'd3591);   // one step anticlockwise from no phase
      send(sspp_pkg::REQ_TICK, 12'hFFF);      // target field ignored on a tick
      send(sspp_pkg::REQ_TICK, 12'd0);        // nothing left to take
      send(sspp_pkg::REQ_TARGET, 12'd1791);   // exactly half a turn back
      repeat (3) send(sspp_pkg::REQ_TICK, 12'd0);
      send(sspp_pkg::REQ_TARGET, 12'd4095);   // above the range, replaces the move
      send(sspp_pkg::REQ_TICK, 12'd0);
      send(sspp_pkg::REQ_TARGET, 12'd3600);
      repeat (3) send(sspp_pkg::REQ_TICK, 12'd0);   // position wraps 399 to 0
      send(sspp_pkg::REQ_TARGET, 12'd1800);   // exactly half a turn forward
      repeat (2) send(sspp_pkg::REQ_TICK, 12'd0);
      send(sspp_pkg::REQ_TARGET, 12'd22);     // rounds to zero steps mid-move
      send(sspp_pkg::REQ_TARGET, 12'd23);     // rounds up to one step
      send(sspp_pkg::REQ_TARGET, 12'd13);
      send(sspp_pkg::REQ_TARGET, 12'd14);
      send(sspp_pkg::REQ_TARGET, 12'h555);
      send(sspp_pkg::REQ_TARGET, 12'hAAA);
      send(sspp_pkg::REQ_TICK, 12'd0);
      drain();

      while (items_sent < ITEM_GOAL) begin
         steady <= (items_sent >= 500 && items_sent < 700);
         if ($urandom_range(99) < 75)
            aim = 12'($urandom_range(3599));
         else
            aim = 12'($urandom_range(4095));
         send(sspp_pkg::REQ_TARGET, aim);
         // mostly short bursts that get cut off, now and then a full move
         ticks = ($urandom_range(99) < 15) ? LONG_RUN : $urandom_range(12);
         repeat (ticks) send(sspp_pkg::REQ_TICK, 12'($urandom));
         if (items_sent >= 900 && !paused_late) begin
            paused_late = 1'b1;
            drain();
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
